/* rtl/core/ossp_pkg.sv */
package ossp_pkg;

    // Size of the sorted table and width of a stored value.
    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 31;

    // Table index and fill count widths. The count must also hold CAPACITY itself.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [1:0]            t_func;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    // Operation codes of a request.
    localparam t_func FUNC_INSERT = 2'd0;
    localparam t_func FUNC_NEXT   = 2'd1;
    localparam t_func FUNC_PREV   = 2'd2;

    // Outcome of the shared magnitude comparator.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

endpackage

/* rtl/core/ossp_if.sv */
// Request channel: operation code and value.
interface ossp_req_if;
    import ossp_pkg::*;

    logic   valid;
    logic   ready;
    t_func  func;
    t_value value;

    modport source (output valid, func, value, input ready);
    modport sink   (input valid, func, value, output ready);
endinterface

// Result channel: one result per request.
interface ossp_rsp_if;
    import ossp_pkg::*;

    logic   valid;
    logic   ready;
    logic   found;
    t_value result_value;
    logic   full_drop;

    modport source (output valid, found, result_value, full_drop, input ready);
    modport sink   (input valid, found, result_value, full_drop, output ready);
endinterface

/* rtl/core/ordered_set_successor_predecessor_top.sv */
// Ordered set of distinct values with insert, successor (next at or above) and
// predecessor (previous at or below) requests. The values are kept in ascending
// order in a single-port table of CAPACITY entries, and one comparator is shared
// by every step. A request is taken only while the sequencer is idle; it then
// runs a binary search in which each halving is a table read (ST_SRCH), then
// a compare (ST_CMP). An insert of a new value also opens a slot by moving
// every entry at or above the insertion point up by one, each with a read,
// then a write through the one memory port, so an insert near the bottom of a
// nearly full table moves nearly every entry. The result sits in an output
// register, so the next request is accepted while an earlier result still
// waits to be taken. The table needs no clearing after reset: only the first
// count entries are ever read. An insert of a new value into a full table is
// dropped and flagged; an unused operation code returns an all-zero result and
// changes nothing.
module ordered_set_successor_predecessor_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ossp_req_if.sink   i_req,
    ossp_rsp_if.source o_rsp
);
    import ossp_pkg::*;

    localparam t_cnt CAP_CNT = CNT_W'(CAPACITY);

    // One-hot sequencer states.
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SRCH = 9'b000000010,
        ST_CMP  = 9'b000000100,
        ST_POST = 9'b000001000,
        ST_CHK  = 9'b000010000,
        ST_SHR  = 9'b000100000,
        ST_SHW  = 9'b001000000,
        ST_RES  = 9'b010000000,
        ST_DONE = 9'b100000000
    } t_state;

    // The sorted table. Reads are registered.
    t_value r_mem [CAPACITY];
    t_value r_rdata;

    logic   rd_en;
    t_idx   rd_addr;
    logic   wr_en;
    t_idx   wr_addr;
    t_value wr_data;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_cnt   r_lo, n_lo;
    t_cnt   r_hi, n_hi;
    t_cnt   r_mid, n_mid;
    t_cnt   r_j, n_j;
    t_func  r_func, n_func;
    t_value r_key, n_key;
    logic   r_found, n_found;
    t_value r_res, n_res;
    logic   r_drop, n_drop;

    logic   r_ovalid, n_ovalid;
    logic   r_ofound;
    t_value r_ores;
    logic   r_odrop;

    logic            load_out;
    logic [CNT_W:0]  mid_sum;
    t_cnt            mid;
    t_cnt            j_dec;
    t_cmp            cmp;
    logic            go_right;

    ossp_cmp u_cmp (
        .i_a   (r_rdata),
        .i_b   (r_key),
        .o_cmp (cmp)
    );

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CNT_W:1];
    assign j_dec   = r_j - t_cnt'(1);

    // A "prev" search looks for the first entry above the key; the others
    // look for the first entry at or above it.
    assign go_right = (r_func == FUNC_PREV) ? (cmp.lt | cmp.eq) : cmp.lt;

    assign i_req.ready = (r_state == ST_IDLE);

    // The result moves to the output register once that register is free.
    assign load_out = (r_state == ST_DONE) && (!r_ovalid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_j     = r_j;
        n_func  = r_func;
        n_key   = r_key;
        n_found = r_found;
        n_res   = r_res;
        n_drop  = r_drop;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_key;

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_key   = i_req.value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_found = 1'b0;
                    n_res   = '0;
                    n_drop  = 1'b0;
                    if (i_req.func == FUNC_INSERT || i_req.func == FUNC_NEXT ||
                        i_req.func == FUNC_PREV) begin
                        n_state = ST_SRCH;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SRCH: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = mid[IDX_W-1:0];
                    n_mid   = mid;
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_POST;
                end
            end
            ST_CMP: begin
                if (go_right) begin
                    n_lo = r_mid + t_cnt'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = ST_SRCH;
            end
            ST_POST: begin
                case (r_func)
                    FUNC_INSERT: begin
                        if (r_lo < r_count) begin
                            rd_en   = 1'b1;
                            rd_addr = r_lo[IDX_W-1:0];
                            n_state = ST_CHK;
                        end else if (r_count >= CAP_CNT) begin
                            n_drop  = 1'b1;
                            n_state = ST_DONE;
                        end else begin
                            n_j     = r_count;
                            n_state = ST_SHR;
                        end
                    end
                    FUNC_NEXT: begin
                        if (r_lo < r_count) begin
                            rd_en   = 1'b1;
                            rd_addr = r_lo[IDX_W-1:0];
                            n_state = ST_RES;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    FUNC_PREV: begin
                        if (r_lo != '0) begin
                            rd_en   = 1'b1;
                            rd_addr = IDX_W'(r_lo - t_cnt'(1));
                            n_state = ST_RES;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_CHK: begin
                if (cmp.eq) begin
                    n_state = ST_DONE;
                end else if (r_count >= CAP_CNT) begin
                    n_drop  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_j     = r_count;
                    n_state = ST_SHR;
                end
            end
            ST_SHR: begin
                if (r_j > r_lo) begin
                    rd_en   = 1'b1;
                    rd_addr = j_dec[IDX_W-1:0];
                    n_state = ST_SHW;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_lo[IDX_W-1:0];
                    wr_data = r_key;
                    n_count = r_count + t_cnt'(1);
                    n_state = ST_DONE;
                end
            end
            ST_SHW: begin
                wr_en   = 1'b1;
                wr_addr = r_j[IDX_W-1:0];
                wr_data = r_rdata;
                n_j     = j_dec;
                n_state = ST_SHR;
            end
            ST_RES: begin
                n_found = 1'b1;
                n_res   = r_rdata;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_j     <= n_j;
        r_func  <= n_func;
        r_key   <= n_key;
        r_found <= n_found;
        r_res   <= n_res;
        r_drop  <= n_drop;
        if (load_out) begin
            r_ofound <= r_found;
            r_ores   <= r_res;
            r_odrop  <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_rsp.valid        = r_ovalid;
    assign o_rsp.found        = r_ofound;
    assign o_rsp.result_value = r_ores;
    assign o_rsp.full_drop    = r_odrop;

endmodule

/* rtl/core/ossp_cmp.sv */
module ossp_cmp (
    input  ossp_pkg::t_value i_a,
    input  ossp_pkg::t_value i_b,
    output ossp_pkg::t_cmp   o_cmp
);
    import ossp_pkg::*;

    // Unsigned compare of a stored entry against the request key.
    always_comb begin
        o_cmp.lt = (i_a < i_b);
        o_cmp.eq = (i_a == i_b);
    end

endmodule
